@@ sv/qlbs_pkg.sv @@
// ----------------------------------------------------------------------------
// qlbs_pkg
// Types, constants and helpers shared by the level bus slave modules.
// ----------------------------------------------------------------------------
package qlbs_pkg;

    localparam int BYTE_W      = 8;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int FRAME_LEN   = 4;
    localparam int REPLY_LEN   = 5;
    localparam int BEAT_W      = $clog2(REPLY_LEN);

    localparam logic [BYTE_W-1:0] CMD_READ      = 8'd10;
    localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'd20;
    localparam logic [BYTE_W-1:0] CMD_ADDR      = 8'd30;
    localparam logic [BYTE_W-1:0] REPLY_CODE    = 8'd50;
    localparam logic [BYTE_W-1:0] LEVEL_TOP     = 8'd255;
    localparam logic [BYTE_W-1:0] NODE_RESET    = 8'd50;
    localparam logic [BYTE_W-1:0] MIN_LVL_RESET = 8'd20;
    localparam logic [BYTE_W-1:0] MASTER_RESET  = 8'd1;

    // Register addresses are decoded on paddr bit 2 of the PADDR_W-bit address.
    localparam int PADDR_W = 3;
    localparam logic REG_LVL_FLOOR   = 1'b0;
    localparam logic REG_MASTER_ADDR = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_BYTE    = 2'd1,
        FUNC_TIMEOUT = 2'd2
    } t_func;

    // Snapshot of the registers that one reply reports.
    typedef struct packed {
        logic [BYTE_W-1:0] master;
        logic [BYTE_W-1:0] level;
        logic [BYTE_W-1:0] sw;
        logic [BYTE_W-1:0] csum;
    } t_reply;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Next code in the increasing sequence 00-10-11-01-00.
    function automatic logic [1:0] gray_up(input logic [1:0] s);
        logic [1:0] r;
        case (s)
            2'b00:   r = 2'b10;
            2'b01:   r = 2'b00;
            2'b10:   r = 2'b11;
            default: r = 2'b01;
        endcase
        return r;
    endfunction

endpackage

@@ sv/qlbs_front.sv @@
// ----------------------------------------------------------------------------
// qlbs_front
// Accepts input items, tracks encoder, button and frame state, and queues a
// reply snapshot whenever a good read, write or address frame completes.
// ----------------------------------------------------------------------------
module qlbs_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [1:0]               i_func,
    input  logic [7:0]               i_rx_byte,
    input  logic [1:0]               i_enc_ab,
    input  logic                     i_button,
    input  logic [7:0]               i_lvl_floor,
    input  logic [7:0]               i_master_addr,
    output logic                     o_push,
    output qlbs_pkg::t_reply         o_reply
);
    import qlbs_pkg::*;

    logic [2:0]        r_byte_count, n_byte_count;
    logic [BYTE_W-1:0] r_frame [FRAME_LEN];
    logic              frame_we;
    logic [BYTE_W-1:0] r_node, n_node;
    logic [BYTE_W-1:0] r_level, n_level;
    logic [BYTE_W-1:0] r_sw, n_sw;
    logic [1:0]        r_enc_prev, n_enc_prev;
    logic              r_btn_prev, n_btn_prev;
    logic [BYTE_W-1:0] frame_sum;
    logic              frame_ok;

    assign frame_sum = r_frame[0] + r_frame[1] + r_frame[2] + r_frame[3];
    assign frame_ok  = (i_rx_byte == frame_sum) && (r_frame[0] == r_node);

    always_comb begin
        n_byte_count = r_byte_count;
        n_node       = r_node;
        n_level      = r_level;
        n_sw         = r_sw;
        n_enc_prev   = r_enc_prev;
        n_btn_prev   = r_btn_prev;
        frame_we     = 1'b0;
        o_push       = 1'b0;
        if (i_accept) begin
            case (i_func)
                FUNC_TICK: begin
                    // Pin samples are ignored while a frame is partly received.
                    if (r_byte_count == 3'd0) begin
                        if (i_enc_ab == gray_up(r_enc_prev)) begin
                            if (r_level != LEVEL_TOP) n_level = r_level + 8'd1;
                        end else if (r_enc_prev == gray_up(i_enc_ab)) begin
                            if (r_level > i_lvl_floor) n_level = r_level - 8'd1;
                        end
                        if (r_btn_prev && !i_button) begin
                            n_sw = (r_sw == 8'd0) ? 8'd1 : 8'd0;
                        end
                        n_enc_prev = i_enc_ab;
                        n_btn_prev = i_button;
                    end
                end
                FUNC_BYTE: begin
                    if (r_byte_count < 3'(FRAME_LEN)) begin
                        frame_we     = 1'b1;
                        n_byte_count = r_byte_count + 3'd1;
                    end else begin
                        n_byte_count = 3'd0;
                        if (frame_ok) begin
                            case (r_frame[1])
                                CMD_READ: begin
                                    o_push = 1'b1;
                                end
                                CMD_WRITE: begin
                                    n_level = (r_frame[2] < i_lvl_floor) ? i_lvl_floor
                                                                         : r_frame[2];
                                    n_sw    = r_frame[3];
                                    o_push  = 1'b1;
                                end
                                CMD_ADDR: begin
                                    n_node = r_frame[2];
                                    o_push = 1'b1;
                                end
                                default: begin
                                    o_push = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                FUNC_TIMEOUT: begin
                    n_byte_count = 3'd0;
                end
                default: begin
                    n_byte_count = r_byte_count;
                end
            endcase
        end
    end

    // The reply reports the registers after this item's update.
    always_comb begin
        o_reply.master = i_master_addr;
        o_reply.level  = n_level;
        o_reply.sw     = n_sw;
        o_reply.csum   = i_master_addr + REPLY_CODE + n_level + n_sw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 3'd0;
            r_node       <= NODE_RESET;
            r_level      <= '0;
            r_sw         <= '0;
            r_enc_prev   <= '0;
            r_btn_prev   <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_node       <= n_node;
            r_level      <= n_level;
            r_sw         <= n_sw;
            r_enc_prev   <= n_enc_prev;
            r_btn_prev   <= n_btn_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            r_frame[r_byte_count[1:0]] <= i_rx_byte;
        end
    end

endmodule

@@ sv/qlbs_fifo.sv @@
// ----------------------------------------------------------------------------
// qlbs_fifo
// Short queue of reply snapshots between the front and the serializer.
// ----------------------------------------------------------------------------
module qlbs_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  qlbs_pkg::t_reply      i_wdata,
    input  logic                  i_pop,
    output qlbs_pkg::t_reply      o_rdata,
    output qlbs_pkg::t_fifo_stat  o_stat
);
    import qlbs_pkg::*;

    t_reply                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr, r_rptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  do_push, do_pop;

    assign o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rdata      = r_mem[r_rptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) r_wptr <= (r_wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (do_pop)  r_rptr <= (r_rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

@@ sv/qlbs_back.sv @@
// ----------------------------------------------------------------------------
// qlbs_back
// Serializes each queued reply snapshot into five output bytes.
// ----------------------------------------------------------------------------
module qlbs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qlbs_pkg::t_reply      i_entry,
    input  qlbs_pkg::t_fifo_stat  i_stat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_tx_byte,
    output logic                  o_last_byte
);
    import qlbs_pkg::*;

    logic              r_busy, n_busy;
    logic [BEAT_W-1:0] r_beat, n_beat;
    t_reply            r_entry;
    logic              last;

    assign last        = (r_beat == BEAT_W'(REPLY_LEN - 1));
    assign o_out_valid = r_busy;
    assign o_last_byte = last;

    always_comb begin
        case (r_beat)
            3'd0:    o_tx_byte = r_entry.master;
            3'd1:    o_tx_byte = REPLY_CODE;
            3'd2:    o_tx_byte = r_entry.level;
            3'd3:    o_tx_byte = r_entry.sw;
            default: o_tx_byte = r_entry.csum;
        endcase
    end

    // A new reply is loaded when idle or as the last byte of the current one leaves.
    always_comb begin
        n_busy = r_busy;
        n_beat = r_beat;
        o_pop  = 1'b0;
        if (!r_busy || (i_out_ready && last)) begin
            o_pop  = !i_stat.empty;
            n_busy = !i_stat.empty;
            n_beat = '0;
        end else if (i_out_ready) begin
            n_beat = r_beat + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else begin
            r_busy <= n_busy;
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

endmodule

@@ sv/quadrature_level_bus_slave.sv @@
// ----------------------------------------------------------------------------
// quadrature_level_bus_slave
// Dimmer node: encoder and button control of a level, serial frame slave.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one item per request:
// i_func selects a pin tick, a received serial byte or a receive timeout.
// Output channel (o_out_valid / i_out_ready) carries reply bytes; each good
// frame with a known command produces five, the fifth flagged by o_last_byte.
// Registers for the level floor (address 0) and master_addr (address 4) are
// written and read over the APB port, which never inserts wait states.
// Input items are accepted while o_in_ready is high. The fifth byte of a
// good frame with a known command queues a reply snapshot at the edge that
// accepts it; the serializer loads it once any earlier reply has gone, and
// the reply then streams at one byte per cycle while i_out_ready is high.
// The reply queue holds two snapshots plus the one being sent; o_in_ready
// drops only while the queue is full, so a stalled receiver blocks input
// only after three replies are pending. The serializer sends each reply as
// five output bytes while new input items keep being accepted.
// Synchronous reset restores the register defaults, clears the level, the
// switch byte, the frame counter and the queue, and sets the node address.
// ----------------------------------------------------------------------------
module quadrature_level_bus_slave (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [1:0]  i_enc_ab,
    input  logic        i_button,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qlbs_pkg::*;

    logic [BYTE_W-1:0] r_lvl_floor;
    logic [BYTE_W-1:0] r_master_addr;
    logic              cfg_we;
    logic              in_accept;
    logic              push, pop;
    t_reply            push_data, head;
    t_fifo_stat        fifo_stat;

    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == REG_MASTER_ADDR) ? {24'd0, r_master_addr}
                                                      : {24'd0, r_lvl_floor};
    assign o_in_ready = !fifo_stat.full;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_floor   <= MIN_LVL_RESET;
            r_master_addr <= MASTER_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == REG_LVL_FLOOR) r_lvl_floor <= pwdata[7:0];
            else                           r_master_addr <= pwdata[7:0];
        end
    end

    qlbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_func        (i_func),
        .i_rx_byte     (i_rx_byte),
        .i_enc_ab      (i_enc_ab),
        .i_button      (i_button),
        .i_lvl_floor   (r_lvl_floor),
        .i_master_addr (r_master_addr),
        .o_push        (push),
        .o_reply       (push_data)
    );

    qlbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_data),
        .i_pop   (pop),
        .o_rdata (head),
        .o_stat  (fifo_stat)
    );

    qlbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head),
        .i_stat      (fifo_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

@@ sv/qlbs_checker.sv @@
// ----------------------------------------------------------------------------
// qlbs_checker
// Port-level checks on the level bus slave, bound to the top level.
// ----------------------------------------------------------------------------
module qlbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_tx_byte,
    input logic       o_last_byte,
    input logic       pready
);

    // A stalled reply byte holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_tx_byte) && $stable(o_last_byte)))
        else $error("reply byte changed or dropped while stalled");

    // A reply is never cut short once its first bytes have left.
    a_reply_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_byte) |=> o_out_valid)
        else $error("reply ended before its last byte");

    // Right after reset nothing is pending and input is open.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind quadrature_level_bus_slave qlbs_checker u_qlbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_tx_byte   (o_tx_byte),
    .o_last_byte (o_last_byte),
    .pready      (pready)
);
